FILE: src/ats_pkg.sv
// ----------------------------------------------------------------------------
// ats_pkg
// Types, codes and constants shared by the alarm table scheduler modules.
// ----------------------------------------------------------------------------
package ats_pkg;

	localparam int TABLE_DEPTH_DEF = 32;
	localparam int MOD_BITS = 34;
	localparam logic [16:0] DAY_SEC = 17'd86400;
	localparam logic [16:0] HOUR_SEC = 17'd3600;
	localparam logic [22:0] DAY_RECIP = 23'd198841;
	localparam logic [22:0] HOUR_RECIP = 23'd4772185;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		REQ_ADD  = 2'd0,
		REQ_CHG  = 2'd1,
		REQ_DEL  = 2'd2,
		REQ_TICK = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		K_ONE     = 3'd0,
		K_DAILY   = 3'd1,
		K_PER     = 3'd2,
		K_RELSHOT = 3'd3,
		K_HOURLY  = 3'd4,
		K_RELNOW  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NOID = 2'd1,
		ST_FULL = 2'd2,
		ST_NDUE = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] entry_id;
		logic [2:0]  alarm_kind;
		logic [31:0] time_value;
		logic        enable;
		logic [31:0] current_time;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] result_id;
		logic        fired;
		logic [31:0] next_deadline;
		logic        deadline_valid;
	} out_item_t;

	typedef struct packed {
		req_t        op;
		logic [15:0] id;
		kind_t       kind;
		logic [31:0] tv;
		logic        en;
		logic [31:0] now;
	} cmd_t;

	typedef struct packed {
		logic [15:0] id;
		kind_t       kind;
		logic [31:0] tv;
		logic [31:0] last;
		logic [31:0] next;
		logic        en;
	} ent_t;

	typedef struct packed {
		logic                start;
		logic                hourly;
		logic [MOD_BITS-1:0] value;
	} mod_req_t;

	typedef struct packed {
		logic        done;
		logic [16:0] rem;
	} mod_rsp_t;

endpackage

FILE: src/ats_chan_if.sv
// ----------------------------------------------------------------------------
// ats_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface ats_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/ats_ram.sv
// ----------------------------------------------------------------------------
// ats_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ats_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/ats_front.sv
// ----------------------------------------------------------------------------
// ats_front
// Accepts request items, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ats_front (
	input  logic             clk,
	input  logic             arst_n,
	ats_chan_if.sink         in_ch,
	output ats_pkg::cmd_t    cmd,
	output logic             cmd_valid,
	input  logic             pop
);
	import ats_pkg::*;

	cmd_t       q_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t       dec;
	logic       push;

	always_comb begin
		dec.op = req_t'(in_ch.data.req_type);
		dec.id = in_ch.data.entry_id;
		dec.kind = (in_ch.data.alarm_kind > 3'd5) ? K_ONE : kind_t'(in_ch.data.alarm_kind);
		dec.tv = in_ch.data.time_value;
		dec.en = in_ch.data.enable;
		dec.now = in_ch.data.current_time;
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign cmd = q_q[rp_q];
	assign cmd_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

FILE: src/ats_mod.sv
// ----------------------------------------------------------------------------
// ats_mod
// Remainder by the day or hour length through reciprocal multiplication;
// operand, quotient estimate, quotient product and remainder are registered in turn.
// ----------------------------------------------------------------------------
module ats_mod (
	input  logic              clk,
	input  logic              arst_n,
	input  ats_pkg::mod_req_t req,
	output ats_pkg::mod_rsp_t rsp
);
	import ats_pkg::*;

	logic [MOD_BITS-1:0]  v_q;
	logic [16:0]          p_q;
	logic [22:0]          m_q;
	logic [22:0]          q_s1;
	logic [MOD_BITS-1:0]  qp_s2;
	logic [16:0]          rem_q;
	logic                 vld_s1, vld_s2, vld_s3, done_q;
	logic [MOD_BITS+22:0] prod;
	logic [MOD_BITS-1:0]  diff;

	// The quotient estimate is exact or one too small, so one subtraction
	// of the period finishes the remainder.
	assign prod = v_q * m_q;
	assign diff = v_q - qp_s2;
	assign rsp.done = done_q;
	assign rsp.rem = rem_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			v_q <= req.value;
			p_q <= req.hourly ? HOUR_SEC : DAY_SEC;
			m_q <= req.hourly ? HOUR_RECIP : DAY_RECIP;
		end
		q_s1 <= prod[MOD_BITS+22:MOD_BITS];
		qp_s2 <= {11'd0, q_s1} * {17'd0, p_q};
		rem_q <= (diff >= MOD_BITS'(p_q)) ? 17'(diff - MOD_BITS'(p_q)) : diff[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= req.start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end
endmodule

FILE: src/ats_back.sv
// ----------------------------------------------------------------------------
// ats_back
// Request sequencer: scans the table, updates entries and re-selects the
// earliest deadline as the request needs it, then presents one result item.
// ----------------------------------------------------------------------------
module ats_back #(
	parameter int TABLE_DEPTH = ats_pkg::TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ats_pkg::cmd_t       cmd,
	input  logic                cmd_valid,
	output logic                pop,
	input  logic signed [17:0]  zone,
	ats_chan_if.source          out_ch
);
	import ats_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_IDSCAN = 9'b000000010,
		S_FIND   = 9'b000000100,
		S_CALC   = 9'b000001000,
		S_ALIGN  = 9'b000010000,
		S_WRITE  = 9'b000100000,
		S_SHIFT  = 9'b001000000,
		S_RESEL  = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t         state_q;
	cmd_t           cmd_q;
	ent_t           ent_q, rdata, wdata;
	logic [CW-1:0]  used_q, ptr_q;
	logic [AW-1:0]  k_q, pidx_s1, waddr;
	logic           pend_s1, we;
	logic [15:0]    last_id_q, target_q, cid_q, bid_q, res_id_q;
	logic [31:0]    cd_q, bd_q;
	logic           cv_q, bv_q, res_fired_q;
	status_t        res_status_q;
	logic           out_valid_q;
	out_item_t      out_q;
	logic           issue, scan_done, hit;
	mod_req_t       mreq;
	mod_rsp_t       mrsp;
	logic [16:0]    per;
	logic signed [34:0] n_base, n_fin;

	ats_ram #(.WIDTH($bits(ent_t)), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (ptr_q[AW-1:0]),
		.rdata (rdata)
	);

	ats_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign issue = (ptr_q < used_q);
	assign scan_done = !issue && !pend_s1;
	assign hit = pend_s1 && (rdata.id == target_q);
	assign pop = (state_q == S_IDLE) && cmd_valid;

	assign per = (ent_q.kind == K_HOURLY) ? HOUR_SEC : DAY_SEC;
	assign mreq.start = (state_q == S_CALC)
		&& (ent_q.kind == K_DAILY || ent_q.kind == K_HOURLY);
	assign mreq.hourly = (ent_q.kind == K_HOURLY);
	assign mreq.value = {2'b00, ent_q.last} + {{16{zone[17]}}, zone} + MOD_BITS'(DAY_SEC);

	always_comb begin
		n_base = $signed({3'b000, ent_q.last}) - $signed({18'd0, mrsp.rem})
			+ $signed({3'b000, ent_q.tv});
		n_fin = n_base;
		if (n_base <= $signed({3'b000, ent_q.last})) begin
			n_fin = n_base + $signed({18'd0, per});
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = k_q;
		wdata = ent_q;
		if (state_q == S_WRITE) begin
			we = 1'b1;
		end else if (state_q == S_SHIFT && pend_s1) begin
			we = 1'b1;
			waddr = pidx_s1 - AW'(1);
			wdata = rdata;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd;
					res_fired_q <= 1'b0;
					res_status_q <= ST_OK;
					res_id_q <= (cmd.op == REQ_CHG || cmd.op == REQ_DEL) ? cmd.id : 16'd0;
					if (cmd.op == REQ_ADD) begin
						target_q <= last_id_q + 16'd1;
						if (used_q == CW'(TABLE_DEPTH)) begin
							res_status_q <= ST_FULL;
						end
					end else if (cmd.op == REQ_TICK) begin
						target_q <= cid_q;
						if (!cv_q || cmd.now < cd_q) begin
							res_status_q <= ST_NDUE;
						end
					end else begin
						target_q <= cmd.id;
					end
				end
			end
			S_IDSCAN: begin
				if (hit) begin
					target_q <= target_q + 16'd1;
				end else if (scan_done) begin
					ent_q.id <= target_q;
					ent_q.kind <= cmd_q.kind;
					ent_q.tv <= cmd_q.tv;
					ent_q.en <= cmd_q.en;
					ent_q.last <= cmd_q.now;
					k_q <= used_q[AW-1:0];
					res_id_q <= target_q;
				end
			end
			S_FIND: begin
				if (hit) begin
					k_q <= pidx_s1;
					ent_q <= rdata;
					if (cmd_q.op == REQ_CHG) begin
						ent_q.kind <= cmd_q.kind;
						ent_q.tv <= cmd_q.tv;
						ent_q.en <= cmd_q.en;
					end else if (cmd_q.op == REQ_TICK) begin
						ent_q.last <= cmd_q.now;
						res_id_q <= target_q;
						res_fired_q <= 1'b1;
					end
				end else if (scan_done) begin
					res_status_q <= (cmd_q.op == REQ_TICK) ? ST_NDUE : ST_NOID;
				end
			end
			S_CALC: begin
				case (ent_q.kind)
					K_DAILY, K_HOURLY: begin
					end
					K_PER: begin
						ent_q.next <= ent_q.last + ent_q.tv;
					end
					K_RELSHOT: begin
						ent_q.next <= ent_q.last + ent_q.tv;
						ent_q.kind <= K_ONE;
					end
					K_RELNOW: begin
						ent_q.last <= cmd_q.now;
						ent_q.next <= cmd_q.now + ent_q.tv;
						ent_q.kind <= K_ONE;
					end
					default: begin
						ent_q.next <= ent_q.tv;
						ent_q.kind <= K_ONE;
					end
				endcase
			end
			S_ALIGN: begin
				if (mrsp.done) begin
					ent_q.next <= n_fin[31:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			ptr_q <= '0;
			pend_s1 <= 1'b0;
			pidx_s1 <= '0;
			last_id_q <= '0;
			cd_q <= '0;
			cid_q <= '0;
			cv_q <= 1'b0;
			bd_q <= '0;
			bid_q <= '0;
			bv_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_IDSCAN || state_q == S_FIND
				|| state_q == S_SHIFT || state_q == S_RESEL) begin
				if (issue) begin
					ptr_q <= ptr_q + CW'(1);
					pidx_s1 <= ptr_q[AW-1:0];
					pend_s1 <= 1'b1;
				end else begin
					pend_s1 <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					ptr_q <= '0;
					pend_s1 <= 1'b0;
					if (cmd_valid) begin
						case (cmd.op)
							REQ_ADD: begin
								state_q <= (used_q == CW'(TABLE_DEPTH)) ? S_DONE : S_IDSCAN;
							end
							REQ_TICK: begin
								state_q <= (!cv_q || cmd.now < cd_q) ? S_DONE : S_FIND;
							end
							default: begin
								state_q <= S_FIND;
							end
						endcase
					end
				end
				S_IDSCAN: begin
					if (hit) begin
						ptr_q <= '0;
						pend_s1 <= 1'b0;
					end else if (scan_done) begin
						last_id_q <= target_q;
						state_q <= S_CALC;
					end
				end
				S_FIND: begin
					if (hit) begin
						if (cmd_q.op == REQ_DEL
							|| (cmd_q.op == REQ_TICK && rdata.kind == K_ONE)) begin
							ptr_q <= CW'(pidx_s1) + CW'(1);
							pend_s1 <= 1'b0;
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_CALC;
						end
					end else if (scan_done) begin
						state_q <= S_DONE;
					end
				end
				S_CALC: begin
					state_q <= (ent_q.kind == K_DAILY || ent_q.kind == K_HOURLY)
						? S_ALIGN : S_WRITE;
				end
				S_ALIGN: begin
					if (mrsp.done) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (cmd_q.op == REQ_ADD) begin
						used_q <= used_q + CW'(1);
					end
					ptr_q <= '0;
					pend_s1 <= 1'b0;
					bv_q <= 1'b0;
					bd_q <= ALL_ONES;
					bid_q <= '0;
					state_q <= S_RESEL;
				end
				S_SHIFT: begin
					if (scan_done) begin
						used_q <= used_q - CW'(1);
						ptr_q <= '0;
						bv_q <= 1'b0;
						bd_q <= ALL_ONES;
						bid_q <= '0;
						state_q <= S_RESEL;
					end
				end
				S_RESEL: begin
					if (pend_s1 && rdata.en && (!bv_q || rdata.next < bd_q)) begin
						bv_q <= 1'b1;
						bd_q <= rdata.next;
						bid_q <= rdata.id;
					end
					if (scan_done) begin
						cv_q <= bv_q;
						cd_q <= bd_q;
						cid_q <= bid_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_q.status <= res_status_q;
						out_q.result_id <= res_id_q;
						out_q.fired <= res_fired_q;
						out_q.next_deadline <= cv_q ? cd_q : ALL_ONES;
						out_q.deadline_valid <= cv_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: src/alarm_table_scheduler.sv
// ----------------------------------------------------------------------------
// alarm_table_scheduler
// Ordered alarm table with add, change, delete and tick requests.
// ----------------------------------------------------------------------------
//  channel  dir  payload      handshake
//  in_ch    in   in_item_t    valid && ready
//  out_ch   out  out_item_t   valid && ready
//  cfg_ch   in   zone_offset  valid && ready, always ready
//
// A request may scan the table slot by slot; an add rescans from the start
// once per candidate id found in use, and daily or hourly entries also pass
// through the remainder unit. Reset clears the table at once. A two-entry
// queue takes requests while the sequencer works or while a result waits in
// the output register.
module alarm_table_scheduler #(
	parameter int TABLE_DEPTH = ats_pkg::TABLE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	ats_chan_if.sink in_ch,
	ats_chan_if.source out_ch,
	ats_chan_if.sink cfg_ch
);
	import ats_pkg::*;

	logic signed [17:0] zone_q;
	cmd_t               cmd;
	logic               cmd_valid, pop;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= '0;
		end else if (cfg_ch.valid) begin
			zone_q <= cfg_ch.data;
		end
	end

	ats_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.pop       (pop)
	);

	ats_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.pop       (pop),
		.zone      (zone_q),
		.out_ch    (out_ch)
	);
endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives add, change, delete and tick requests into the alarm table scheduler
// under random idling on both channels. An alarm table model predicts status,
// ids and the selected deadline of every request, and each result is compared
// with the oldest prediction.
// ----------------------------------------------------------------------------
import ats_pkg::*;

typedef logic signed [17:0] zone_t;

class alarm_scoreboard;
	typedef struct {
		logic [15:0] id;
		logic [2:0]  kind;
		logic [31:0] tv;
		logic [31:0] last;
		logic [31:0] next;
		bit          en;
	} alarm_slot_t;

	alarm_slot_t slots[$];
	logic [15:0] issued_id;
	logic [31:0] deadline;
	logic [15:0] deadline_id;
	bit          deadline_ok;
	longint      zone;
	out_item_t   expected_results[$];
	int          errors;

	function new();
		issued_id = '0;
		deadline = '0;
		deadline_id = '0;
		deadline_ok = 0;
		zone = 0;
		errors = 0;
	endfunction

	function void set_zone(zone_t z);
		zone = z;
	endfunction

	function int find_id(logic [15:0] id);
		for (int i = 0; i < slots.size(); i++)
			if (slots[i].id == id)
				return i;
		return -1;
	endfunction

	function logic [31:0] align_to(logic [31:0] last, logic [31:0] t, longint period);
		longint l, loc, m, n;
		l = last;
		loc = l + zone;
		m = ((loc % period) + period) % period;
		n = loc - m + longint'(t) - zone;
		if (n <= l)
			n += period;
		return n[31:0];
	endfunction

	function void rearm(int k, logic [31:0] now);
		case (slots[k].kind)
			K_DAILY: slots[k].next = align_to(slots[k].last, slots[k].tv, 86400);
			K_PER: slots[k].next = slots[k].last + slots[k].tv;
			K_RELSHOT: begin
				slots[k].next = slots[k].last + slots[k].tv;
				slots[k].kind = K_ONE;
			end
			K_HOURLY: slots[k].next = align_to(slots[k].last, slots[k].tv, 3600);
			K_RELNOW: begin
				slots[k].last = now;
				slots[k].next = now + slots[k].tv;
				slots[k].kind = K_ONE;
			end
			default: begin
				slots[k].kind = K_ONE;
				slots[k].next = slots[k].tv;
			end
		endcase
	endfunction

	function void pick_earliest();
		deadline_ok = 0;
		deadline = ALL_ONES;
		deadline_id = '0;
		foreach (slots[i]) begin
			if (slots[i].en && (!deadline_ok || slots[i].next < deadline)) begin
				deadline_ok = 1;
				deadline = slots[i].next;
				deadline_id = slots[i].id;
			end
		end
	endfunction

	function void note_request(in_item_t it);
		out_item_t r;
		alarm_slot_t s;
		logic [2:0] kind;
		int k;
		r = '0;
		kind = (it.alarm_kind > 3'd5) ? 3'(K_ONE) : it.alarm_kind;
		case (it.req_type)
			REQ_ADD: begin
				if (slots.size() >= TABLE_DEPTH_DEF) begin
					r.status = ST_FULL;
				end else begin
					do
						issued_id = issued_id + 16'd1;
					while (find_id(issued_id) >= 0);
					s.id = issued_id;
					s.kind = kind;
					s.tv = it.time_value;
					s.en = it.enable;
					s.last = it.current_time;
					s.next = '0;
					slots.push_back(s);
					rearm(slots.size() - 1, it.current_time);
					pick_earliest();
					r.result_id = issued_id;
				end
			end
			REQ_CHG, REQ_DEL: begin
				r.result_id = it.entry_id;
				k = find_id(it.entry_id);
				if (k < 0) begin
					r.status = ST_NOID;
				end else begin
					if (it.req_type == REQ_CHG) begin
						slots[k].kind = kind;
						slots[k].tv = it.time_value;
						slots[k].en = it.enable;
						rearm(k, it.current_time);
					end else begin
						slots.delete(k);
					end
					pick_earliest();
				end
			end
			default: begin
				if (!deadline_ok) begin
					pick_earliest();
					r.status = ST_NDUE;
				end else if (it.current_time < deadline) begin
					r.status = ST_NDUE;
				end else begin
					k = find_id(deadline_id);
					if (k < 0) begin
						r.status = ST_NDUE;
					end else begin
						r.result_id = deadline_id;
						r.fired = 1'b1;
						if (slots[k].kind == K_ONE) begin
							slots.delete(k);
						end else begin
							slots[k].last = it.current_time;
							rearm(k, it.current_time);
						end
						pick_earliest();
					end
				end
			end
		endcase
		r.next_deadline = deadline_ok ? deadline : ALL_ONES;
		r.deadline_valid = deadline_ok;
		expected_results.push_back(r);
	endfunction

	function void check_result(out_item_t got);
		out_item_t want;
		if (expected_results.size() == 0) begin
			$error("result with no request pending: %p", got);
			errors++;
			return;
		end
		want = expected_results.pop_front();
		if (got.status !== want.status) begin
			$error("status expected %0d actual %0d", want.status, got.status);
			errors++;
		end
		if (got.result_id !== want.result_id) begin
			$error("result_id expected %0d actual %0d", want.result_id, got.result_id);
			errors++;
		end
		if (got.fired !== want.fired) begin
			$error("fired expected %0d actual %0d", want.fired, got.fired);
			errors++;
		end
		if (got.next_deadline !== want.next_deadline) begin
			$error("next_deadline expected %0h actual %0h", want.next_deadline,
				got.next_deadline);
			errors++;
		end
		if (got.deadline_valid !== want.deadline_valid) begin
			$error("deadline_valid expected %0d actual %0d", want.deadline_valid,
				got.deadline_valid);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;

	ats_chan_if #(.T(in_item_t)) in_ch ();
	ats_chan_if #(.T(out_item_t)) out_ch ();
	ats_chan_if #(.T(zone_t)) cfg_ch ();

	alarm_table_scheduler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	alarm_scoreboard alarms = new();
	logic [31:0] clock_now = 32'd1000;
	bit hold_req = 0;
	bit send_burst = 0;
	int idle_cycles = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_request(in_item_t it);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do
			@(posedge clk);
		while (!in_ch.ready);
		alarms.note_request(it);
	endtask

	task automatic request(req_t op, logic [15:0] id, logic [2:0] kind,
			logic [31:0] tv, logic en, logic [31:0] now);
		in_item_t it;
		it.req_type = op;
		it.entry_id = id;
		it.alarm_kind = kind;
		it.time_value = tv;
		it.enable = en;
		it.current_time = now;
		send_request(it);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (alarms.expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_zone(zone_t z);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= z;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		alarms.set_zone(z);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_request(int add_pct);
		in_item_t it;
		int r;
		it.entry_id = $urandom;
		if (alarms.slots.size() > 0 && $urandom_range(0, 9) < 8)
			it.entry_id = alarms.slots[$urandom_range(0, alarms.slots.size() - 1)].id;
		it.alarm_kind = $urandom_range(0, 7);
		it.enable = ($urandom_range(0, 7) != 0);
		if ($urandom_range(0, 19) == 0)
			clock_now = $urandom;
		else
			clock_now = clock_now + $urandom_range(0, 40);
		r = $urandom_range(0, 99);
		if (r < add_pct)
			it.req_type = REQ_ADD;
		else if (r < add_pct + 15)
			it.req_type = REQ_CHG;
		else if (r < add_pct + 25)
			it.req_type = REQ_DEL;
		else
			it.req_type = REQ_TICK;
		if (it.req_type == REQ_TICK && alarms.deadline_ok && $urandom_range(0, 3) != 0)
			clock_now = alarms.deadline + $urandom_range(0, 2);
		it.current_time = clock_now;
		case (it.alarm_kind)
			K_DAILY: it.time_value = $urandom_range(0, 86399);
			K_HOURLY: it.time_value = $urandom_range(0, 3599);
			K_PER, K_RELSHOT, K_RELNOW: it.time_value = $urandom_range(0, 300);
			default: it.time_value = clock_now + $urandom_range(0, 200);
		endcase
		if ($urandom_range(0, 7) == 0)
			it.time_value = $urandom;
		send_request(it);
	endtask

	task automatic random_phase(int count, int add_pct, bit with_hold);
		for (int i = 0; i < count; i++) begin
			if (i % 30 == 0)
				send_burst = ($urandom_range(0, 2) == 0);
			if (with_hold && i == count / 2)
				hold_req = 1;
			random_request(add_pct);
		end
		drain();
	endtask

	initial begin
		int stall;
		int n;
		bit fast;
		n = 0;
		fast = 0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (n % 30 == 0)
				fast = ($urandom_range(0, 2) == 0);
			n++;
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end
			stall = fast ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_ch.valid);
			alarms.check_result(out_ch.data);
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_zone(18'sd3600);
		request(REQ_TICK, 16'd0, K_ONE, 32'd0, 1'b1, 32'd0);
		request(REQ_DEL, 16'd5, K_ONE, 32'd0, 1'b1, 32'd1000);
		request(REQ_CHG, 16'hFFFF, 3'd7, ALL_ONES, 1'b1, 32'd1000);
		request(REQ_ADD, 16'hFFFF, K_ONE, 32'd2000, 1'b1, 32'd1000);
		request(REQ_ADD, 16'd0, K_DAILY, 32'd0, 1'b1, 32'd1000);
		request(REQ_ADD, 16'd0, K_PER, 32'd100, 1'b1, 32'd1000);
		request(REQ_ADD, 16'd0, K_RELSHOT, 32'd50, 1'b1, 32'd1000);
		request(REQ_ADD, 16'd0, K_HOURLY, 32'd3599, 1'b1, 32'd1000);
		request(REQ_ADD, 16'd0, K_RELNOW, 32'd10, 1'b1, 32'd1000);
		request(REQ_ADD, 16'd0, 3'd6, 32'd1500, 1'b1, 32'd1000);
		request(REQ_ADD, 16'd0, 3'd7, ALL_ONES, 1'b0, 32'd1000);
		request(REQ_TICK, 16'd0, K_ONE, 32'd0, 1'b0, 32'd999);
		request(REQ_TICK, 16'd0, K_ONE, 32'd0, 1'b0, 32'd1010);
		request(REQ_CHG, 16'd3, K_PER, 32'd0, 1'b1, 32'd1005);
		request(REQ_TICK, 16'd0, K_ONE, 32'd0, 1'b0, 32'd1000);
		request(REQ_DEL, 16'd1, K_ONE, 32'd0, 1'b0, 32'd1000);
		request(REQ_ADD, 16'd0, K_ONE, ALL_ONES, 1'b1, ALL_ONES);
		request(REQ_ADD, 16'd0, K_DAILY, 32'd86399, 1'b1, 32'd0);
		request(REQ_ADD, 16'd0, K_HOURLY, 32'd0, 1'b1, ALL_ONES);
		request(REQ_CHG, 16'd2, K_RELNOW, 32'd5, 1'b0, 32'd2000);
		request(REQ_TICK, 16'd0, K_ONE, 32'd0, 1'b1, ALL_ONES);
		request(REQ_TICK, 16'd0, K_ONE, 32'd0, 1'b1, ALL_ONES);
		drain();

		write_zone(-18'sd86399);
		random_phase(110, 60, 0);
		write_zone(18'sd86399);
		random_phase(110, 30, 1);
		write_zone(zone_t'($urandom_range(0, 172798)) - 18'sd86399);
		random_phase(110, 45, 0);
		write_zone(18'sd0);
		random_phase(110, 35, 0);

		repeat (100) @(posedge clk);
		if (alarms.errors == 0 && alarms.expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
